@@ rtl/core/sfir_pkg.sv @@
// Shared types and constants for the folded symmetric FIR filter.
// Used by sfir_cell, sfir_mac and symmetric_fir_filter_top; no dependencies.
package sfir_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 16;
  localparam int CIDX_W    = 5;
  localparam int TAP_W     = 6;
  localparam int SCALE_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  // Input transaction kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PRESET = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT  = 1'b0,
    CFG_SCALE_LOG2 = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          coeff_index;
    logic signed [COEF_W-1:0]   coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic [TAP_W-1:0]           fill_count;
    logic                       filled;
  } out_item_t;

  // History cell operations
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROT,
    CELL_PRESET
  } cell_op_t;

  // Broadcast control for the row of cells
  typedef struct packed {
    cell_op_t              op;
    logic [SAMPLE_W-1:0]   value;
    logic [COEF_W-1:0]     coef;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/sfir_cell.sv @@
// One tap cell: a history word and a coefficient word.
// Depends on sfir_pkg for the cell control struct.
module sfir_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sfir_pkg::cell_ctrl_t             ctrl,
  input  logic                             coef_we,
  input  logic [sfir_pkg::SAMPLE_W-1:0]    shift_in,
  input  logic [sfir_pkg::SAMPLE_W-1:0]    rot_in,
  output logic [sfir_pkg::SAMPLE_W-1:0]    hist,
  output logic [sfir_pkg::COEF_W-1:0]      coef
);

  logic [sfir_pkg::SAMPLE_W-1:0] hist_r, hist_nxt;
  logic [sfir_pkg::COEF_W-1:0]   coef_r, coef_nxt;

  // History word: hold, shift from lower neighbor, rotate from upper, preset
  always_comb begin
    unique case (ctrl.op)
      sfir_pkg::CELL_HOLD:   hist_nxt = hist_r;
      sfir_pkg::CELL_SHIFT:  hist_nxt = shift_in;
      sfir_pkg::CELL_ROT:    hist_nxt = rot_in;
      sfir_pkg::CELL_PRESET: hist_nxt = ctrl.value;
      default:               hist_nxt = hist_r;
    endcase
  end

  assign coef_nxt = coef_we ? ctrl.coef : coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      coef_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign hist = hist_r;
  assign coef = coef_r;

endmodule

@@ rtl/core/sfir_mac.sv @@
// Multiply-accumulate unit with power-of-two output scaling.
// Depends on sfir_pkg for widths.
module sfir_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  logic                                 issue,
  input  logic signed [sfir_pkg::COEF_W-1:0]   coef,
  input  logic [sfir_pkg::SAMPLE_W-1:0]        data,
  input  logic [sfir_pkg::SCALE_W-1:0]         scale,
  output logic [sfir_pkg::SAMPLE_W-1:0]        scaled,
  output logic                                 prod_valid
);

  logic [sfir_pkg::SAMPLE_W-1:0] prod_r, prod_nxt;
  logic                          prod_v_r, prod_v_nxt;
  logic [sfir_pkg::SAMPLE_W-1:0] acc_r, acc_nxt;
  logic [sfir_pkg::SAMPLE_W-1:0] coef_ext;

  // Product stage, wrapped to 32 bits
  assign coef_ext   = sfir_pkg::SAMPLE_W'(coef);
  assign prod_nxt   = sfir_pkg::SAMPLE_W'(coef_ext * data);
  assign prod_v_nxt = issue && !clear;

  // Accumulator stage
  always_comb begin
    if (clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + prod_r;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Scaling: left shift, or rounded arithmetic right shift (limited to 31)
  logic [sfir_pkg::SCALE_W-1:0]  neg_s;
  logic [4:0]                    rsh;
  logic [sfir_pkg::SAMPLE_W-1:0] rnd;
  logic [sfir_pkg::SAMPLE_W-1:0] biased;

  always_comb begin
    neg_s  = sfir_pkg::SCALE_W'(0) - scale;
    rsh    = neg_s[5] ? 5'd31 : neg_s[4:0];
    rnd    = sfir_pkg::SAMPLE_W'(1) << (rsh - 5'd1);
    biased = acc_r + rnd;
    if (scale == '0) begin
      scaled = acc_r;
    end else if (!scale[5]) begin
      scaled = acc_r << scale[4:0];
    end else begin
      scaled = sfir_pkg::SAMPLE_W'($signed(biased) >>> rsh);
    end
  end

  assign prod_valid = prod_v_r;

endmodule

@@ rtl/core/symmetric_fir_filter_top.sv @@
// Folded symmetric FIR filter top level: sequencer, row of tap cells, MAC.
// Depends on sfir_pkg, sfir_cell and sfir_mac.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_valid / in_ready   | in_data  (sfir_pkg::in_item_t)
//  out_    | out | out_valid / out_ready | out_data (sfir_pkg::out_item_t)
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// After a sample is accepted, in_ready stays low until its scaled result is registered:
// the shift happens on the accepting edge, then MAX_TAPS rotation steps of the
// history ring (one multiply per tap in use), one accumulator drain and one scaling step
// that stalls on a held result. Preset, clear and coefficient load give no result.
// Synchronous active-low reset zeroes history, coefficients and fill level.
// A waiting result does not block the next item; a finished sample stalls behind it.
module symmetric_fir_filter_top #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  sfir_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output sfir_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sfir_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  sfir_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]                    step_r, step_nxt;
  logic [sfir_pkg::TAP_W-1:0]       fill_r, fill_nxt;
  logic [sfir_pkg::TAP_W-1:0]       tap_count_r, tap_count_nxt;
  logic [sfir_pkg::SCALE_W-1:0]     scale_r, scale_nxt;
  logic                             out_valid_r, out_valid_nxt;
  sfir_pkg::out_item_t              out_data_r, out_data_nxt;

  logic [sfir_pkg::TAP_W-1:0]       taps_n;
  logic                             in_acc;
  logic                             out_load;
  logic                             issue;
  logic                             mac_clear;
  logic [IW-1:0]                    cidx;
  sfir_pkg::cell_ctrl_t             ctrl;
  logic [sfir_pkg::SAMPLE_W-1:0]    scaled;
  logic                             prod_valid;

  logic [sfir_pkg::SAMPLE_W-1:0]    hist [MAX_TAPS];
  logic [sfir_pkg::COEF_W-1:0]      coef [MAX_TAPS];
  logic [MAX_TAPS-1:0]              coef_we;

  // Taps in use: zero counts as one, clamp to MAX_TAPS
  always_comb begin
    if (tap_count_r == '0) begin
      taps_n = sfir_pkg::TAP_W'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      taps_n = sfir_pkg::TAP_W'(MAX_TAPS);
    end else begin
      taps_n = tap_count_r;
    end
  end

  assign in_ready  = (state_r == sfir_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == sfir_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      sfir_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_acc && in_data.kind == sfir_pkg::KIND_SAMPLE) begin
          state_nxt = sfir_pkg::ST_ROT;
        end
      end
      sfir_pkg::ST_ROT: begin
        if (int'(step_r) == MAX_TAPS - 1) begin
          state_nxt = sfir_pkg::ST_DRAIN;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + IW'(1);
        end
      end
      sfir_pkg::ST_DRAIN: state_nxt = sfir_pkg::ST_DONE;
      sfir_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = sfir_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfir_pkg::ST_IDLE;
    endcase
  end

  // Coefficient position for the current step: mirrored over the fold
  always_comb begin
    int mirror;
    mirror = int'(taps_n) - 1 - int'(step_r);
    if (int'(step_r) < mirror) begin
      cidx = step_r;
    end else begin
      cidx = IW'(mirror);
    end
  end

  // Output logic: cell control, MAC control
  always_comb begin
    ctrl.value = in_data.sample;
    ctrl.coef  = in_data.coeff_value;
    ctrl.op    = sfir_pkg::CELL_HOLD;
    issue      = 1'b0;
    mac_clear  = 1'b0;
    unique case (state_r)
      sfir_pkg::ST_IDLE: begin
        if (in_acc && in_data.kind == sfir_pkg::KIND_SAMPLE) begin
          ctrl.op   = sfir_pkg::CELL_SHIFT;
          mac_clear = 1'b1;
        end else if (in_acc && in_data.kind == sfir_pkg::KIND_PRESET) begin
          ctrl.op = sfir_pkg::CELL_PRESET;
        end
      end
      sfir_pkg::ST_ROT: begin
        ctrl.op = sfir_pkg::CELL_ROT;
        issue   = (int'(step_r) < int'(taps_n));
      end
      sfir_pkg::ST_DRAIN, sfir_pkg::ST_DONE: ctrl.op = sfir_pkg::CELL_HOLD;
      default: ctrl.op = sfir_pkg::CELL_HOLD;
    endcase
  end

  // Row of tap cells: shift toward the tail, rotate toward the head
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int NEXT = (i + 1) % MAX_TAPS;
    localparam int PREV = (i == 0) ? 0 : i - 1;
    logic [sfir_pkg::SAMPLE_W-1:0] shift_src;

    if (i == 0) begin : g_head
      assign shift_src = in_data.sample;
    end else begin : g_body
      assign shift_src = hist[PREV];
    end

    assign coef_we[i] = in_acc && (in_data.kind == sfir_pkg::KIND_LOAD)
                        && (int'(in_data.coeff_index) == i);

    sfir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .coef_we  (coef_we[i]),
      .shift_in (shift_src),
      .rot_in   (hist[NEXT]),
      .hist     (hist[i]),
      .coef     (coef[i])
    );
  end

  sfir_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (mac_clear),
    .issue      (issue),
    .coef       (coef[cidx]),
    .data       (hist[0]),
    .scale      (scale_r),
    .scaled     (scaled),
    .prod_valid (prod_valid)
  );

  // Fill level
  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      unique case (in_data.kind)
        sfir_pkg::KIND_SAMPLE: begin
          if (fill_r < taps_n) begin
            fill_nxt = fill_r + sfir_pkg::TAP_W'(1);
          end
        end
        sfir_pkg::KIND_PRESET: fill_nxt = taps_n;
        sfir_pkg::KIND_CLEAR:  fill_nxt = '0;
        sfir_pkg::KIND_LOAD:   fill_nxt = fill_r;
        default:               fill_nxt = fill_r;
      endcase
    end
  end

  // Configuration registers
  always_comb begin
    tap_count_nxt = tap_count_r;
    scale_nxt     = scale_r;
    if (cfg_valid && cfg_ready) begin
      unique case (sfir_pkg::cfg_reg_t'(cfg_index))
        sfir_pkg::CFG_TAP_COUNT:  tap_count_nxt = cfg_data;
        sfir_pkg::CFG_SCALE_LOG2: scale_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_data_nxt.filtered   = scaled;
      out_data_nxt.fill_count = fill_r;
      out_data_nxt.filled     = (fill_r >= taps_n);
      out_valid_nxt           = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfir_pkg::ST_IDLE;
      step_r      <= '0;
      fill_r      <= '0;
      tap_count_r <= sfir_pkg::TAP_W'(1);
      scale_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fill_r      <= fill_nxt;
      tap_count_r <= tap_count_nxt;
      scale_r     <= scale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_sample_starts_rot: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == sfir_pkg::KIND_SAMPLE |=> state_r == sfir_pkg::ST_ROT)
    else $error("sample did not start the rotation pass");

  a_prod_only_after_rot: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid |-> $past(state_r) == sfir_pkg::ST_ROT)
    else $error("product issued outside the rotation pass");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= MAX_TAPS)
    else $error("fill level beyond history depth");

  a_rot_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sfir_pkg::ST_ROT && int'(step_r) == MAX_TAPS - 1
      |=> state_r == sfir_pkg::ST_DRAIN)
    else $error("rotation pass did not end after a full ring turn");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

@@ sim/symmetric_fir_filter_top_test.sv @@
// Self-checking testbench for symmetric_fir_filter_top: directed and random sample,
// preset, clear and coefficient-load traffic, checked against a folded FIR predictor.
// Depends on sfir_pkg and the symmetric_fir_filter_top RTL.
module symmetric_fir_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfir_pkg::*;

  localparam int MAX_TAPS = 32;
  localparam int SETTLE_CYCLES = MAX_TAPS + 8;
  localparam int RANDOM_ITEMS = 850;

  // Predicts filter results per accepted transaction and checks them in order
  class fir_scoreboard;
    logic [SAMPLE_W-1:0] history [MAX_TAPS];
    logic [COEF_W-1:0]   coefs [MAX_TAPS];
    logic [TAP_W-1:0]    fill_level;
    logic [TAP_W-1:0]    tap_count;
    logic [SCALE_W-1:0]  scale_log2;
    out_item_t           expected_q [$];
    int                  mismatches;

    function new();
      foreach (history[k]) history[k] = '0;
      foreach (coefs[k]) coefs[k] = '0;
      fill_level = '0;
      tap_count = TAP_W'(1);
      scale_log2 = '0;
      mismatches = 0;
    endfunction

    function void write_register(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
      case (r)
        CFG_TAP_COUNT:  tap_count = d;
        CFG_SCALE_LOG2: scale_log2 = d;
        default: ;
      endcase
    endfunction

    // Zero counts as one tap, anything past the array as the full array
    function int taps_in_use();
      if (tap_count == 0) return 1;
      if (tap_count > MAX_TAPS) return MAX_TAPS;
      return tap_count;
    endfunction

    // Positive exponent shifts left; negative rounds half up, then shifts right
    function logic [SAMPLE_W-1:0] scale_sum(logic [SAMPLE_W-1:0] sum);
      int s;
      int r;
      logic [SAMPLE_W-1:0] biased;
      s = scale_log2;
      if (s == 0) return sum;
      if (!scale_log2[SCALE_W-1]) return sum << s;
      r = 64 - s;
      if (r > 31) r = 31;
      biased = sum + (32'd1 << (r - 1));
      return $signed(biased) >>> r;
    endfunction

    function void take_input(in_item_t it);
      int n;
      int half;
      logic [SAMPLE_W-1:0] sum;
      logic [SAMPLE_W-1:0] cw;
      out_item_t res;
      n = taps_in_use();
      case (it.kind)
        KIND_PRESET: begin
          foreach (history[k]) history[k] = it.sample;
          fill_level = TAP_W'(n);
        end
        KIND_CLEAR: fill_level = '0;
        KIND_LOAD:  coefs[it.coeff_index] = it.coeff_value;
        default: begin
          for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
          history[0] = it.sample;
          // folded sum: one coefficient per mirrored tap pair, and the odd middle tap
          sum = '0;
          half = n / 2;
          for (int k = 0; k < half; k++) begin
            cw = {{(SAMPLE_W-COEF_W){coefs[k][COEF_W-1]}}, coefs[k]};
            sum = sum + cw * (history[k] + history[n-1-k]);
          end
          if (n % 2 == 1) begin
            cw = {{(SAMPLE_W-COEF_W){coefs[half][COEF_W-1]}}, coefs[half]};
            sum = sum + cw * history[half];
          end
          if (fill_level < n) fill_level = fill_level + 1'b1;
          res.filtered = scale_sum(sum);
          res.fill_count = fill_level;
          res.filled = (fill_level >= n);
          expected_q.push_back(res);
        end
      endcase
    endfunction

    function void check_output(out_item_t got);
      out_item_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: filtered=%h fill_count=%0d filled=%0b",
                   got.filtered, got.fill_count, got.filled);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.filtered !== exp_res.filtered || got.fill_count !== exp_res.fill_count ||
          got.filled !== exp_res.filled) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: filtered exp %h got %h, fill_count exp %0d got %0d, %s",
                   exp_res.filtered, got.filtered, exp_res.fill_count, got.fill_count,
                   $sformatf("filled exp %0b got %0b", exp_res.filled, got.filled));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  bit in_idling = 1'b1;
  bit out_idling = 1'b1;

  fir_scoreboard fir_check = new();

  symmetric_fir_filter_top #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input transaction: optional idle burst, then hold valid until accepted
  task automatic push_input(in_item_t it);
    if (in_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    fir_check.take_input(it);
  endtask

  task automatic write_register(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    fir_check.write_register(r, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop input, wait for every expected result, then let a sample pass fully finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (fir_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_item(kind_t k, logic [SAMPLE_W-1:0] s,
                                         logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] c);
    in_item_t it;
    it.kind = k;
    it.sample = s;
    it.coeff_index = idx;
    it.coeff_value = c;
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2, 3: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 9))
      0:          return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2, 3, 4: return 16'($urandom_range(0, 64)) - 16'd32;
      default:    return 16'($urandom);
    endcase
  endfunction

  // Mostly samples, with loads, clears and presets mixed in
  function automatic in_item_t random_item();
    int r;
    kind_t k;
    r = $urandom_range(0, 99);
    if (r < 72) k = KIND_SAMPLE;
    else if (r < 88) k = KIND_LOAD;
    else if (r < 94) k = KIND_CLEAR;
    else k = KIND_PRESET;
    return make_item(k, random_word(), CIDX_W'($urandom_range(0, 31)), random_coef());
  endfunction

  // Result side: random stall bursts while idling is enabled
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (out_idling && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) fir_check.check_output(out_data);
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int items;
    int taps;
    int len;
    logic [CFG_DAT_W-1:0] tap_sel;
    logic [CFG_DAT_W-1:0] scale_sel;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one tap, no scaling, all coefficients zero
    push_input(make_item(KIND_SAMPLE, 32'h7FFF_FFFF, '0, '0));
    push_input(make_item(KIND_LOAD, '0, 5'd0, 16'h8000));
    push_input(make_item(KIND_SAMPLE, 32'h8000_0000, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'hFFFF_FFFF, '0, '0));
    push_input(make_item(KIND_LOAD, '0, 5'd31, 16'h7FFF));
    push_input(make_item(KIND_CLEAR, '0, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'h0000_0001, '0, '0));
    push_input(make_item(KIND_PRESET, 32'h8000_0000, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'h1234_5678, '0, '0));

    // full length, strongest right shift; clear drops filled back to 0
    drain_and_settle();
    write_register(CFG_TAP_COUNT, 6'd32);
    write_register(CFG_SCALE_LOG2, 6'(-31));
    push_input(make_item(KIND_PRESET, 32'h7FFF_FFFF, '0, '0));
    push_input(make_item(KIND_LOAD, '0, 5'd15, 16'hFFFF));
    push_input(make_item(KIND_SAMPLE, 32'h7FFF_FFFF, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'h8000_0000, '0, '0));
    push_input(make_item(KIND_CLEAR, '0, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'h0000_0005, '0, '0));

    // tap count past the array, largest left shift
    drain_and_settle();
    write_register(CFG_TAP_COUNT, 6'd63);
    write_register(CFG_SCALE_LOG2, 6'd31);
    push_input(make_item(KIND_SAMPLE, 32'hFFFF_FFFF, '0, '0));
    push_input(make_item(KIND_PRESET, 32'h0000_0003, '0, '0));

    // zero taps act as one; scale of -32 acts as -31
    drain_and_settle();
    write_register(CFG_TAP_COUNT, 6'd0);
    write_register(CFG_SCALE_LOG2, 6'(-32));
    push_input(make_item(KIND_SAMPLE, 32'h4000_0000, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'hC000_0000, '0, '0));

    // fill level stays above a tap count that shrinks under it
    drain_and_settle();
    write_register(CFG_TAP_COUNT, 6'd33);
    push_input(make_item(KIND_PRESET, 32'hFFFF_FFFF, '0, '0));
    drain_and_settle();
    write_register(CFG_TAP_COUNT, 6'd4);
    write_register(CFG_SCALE_LOG2, 6'd1);
    push_input(make_item(KIND_SAMPLE, 32'h0000_0002, '0, '0));
    push_input(make_item(KIND_SAMPLE, 32'h0000_0007, '0, '0));

    // random phases: new settings, a coefficient set, then a mixed stream
    items = 0;
    while (items < RANDOM_ITEMS) begin
      drain_and_settle();
      if (items >= RANDOM_ITEMS - 120) begin
        in_idling = 1'b0;
        out_idling = 1'b0;
      end else begin
        in_idling = ($urandom_range(0, 3) != 0);
        out_idling = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 7))
        0:       tap_sel = 6'd1;
        1:       tap_sel = 6'd32;
        2:       tap_sel = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
        3:       tap_sel = 6'($urandom_range(2, 5));
        default: tap_sel = 6'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 5))
        0:       scale_sel = '0;
        1:       scale_sel = 6'($urandom_range(1, 31));
        2, 3:    scale_sel = 6'(64 - $urandom_range(1, 8));
        default: scale_sel = 6'($urandom_range(0, 63));
      endcase
      write_register(CFG_TAP_COUNT, tap_sel);
      write_register(CFG_SCALE_LOG2, scale_sel);
      taps = fir_check.taps_in_use();
      for (int k = 0; k <= (taps - 1) / 2; k++) begin
        push_input(make_item(KIND_LOAD, $urandom, CIDX_W'(k), random_coef()));
        items++;
      end
      len = $urandom_range(30, 90);
      repeat (len) begin
        push_input(random_item());
        items++;
      end
    end

    drain_and_settle();
    if (fir_check.mismatches == 0 && fir_check.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sfir_pkg.sv
rtl/core/sfir_cell.sv
rtl/core/sfir_mac.sv
rtl/core/symmetric_fir_filter_top.sv
sim/symmetric_fir_filter_top_test.sv
